/* src/spjq_pkg.sv */
// Shared types and constants for the sorted priority job queue.
// Used by spjq_cell and sorted_priority_job_queue; depends on nothing.
`timescale 1ns / 1ps

package spjq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 32;

   localparam int PRIO_W      = 4;
   localparam int PAY_LOW_W   = 64;
   localparam int PAY_HIGH_W  = 40;
   localparam int STATUS_W    = 2;
   localparam int JOB_W       = PRIO_W + PAY_LOW_W + PAY_HIGH_W;
   localparam int TDATA_W     = ((JOB_W + 7) / 8) * 8;

   localparam logic [PRIO_W-1:0] TOP_PRIORITY = PRIO_W'(9);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DUMP   = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DUMPED   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic [PAY_HIGH_W-1:0] pay_high;
      logic [PAY_LOW_W-1:0]  pay_low;
      logic [PRIO_W-1:0]     prio;
   } job_type;

   // Broadcast to every cell of the chain in each cycle.
   typedef struct packed {
      logic    insert;
      logic    dump_shift;
      job_type new_job;
   } cell_ctrl_type;

endpackage

/* src/sorted_priority_job_queue.sv */
// Top level of the sorted priority job queue: the chain of slot cells, the
// occupancy count and the result register. Depends on spjq_pkg and spjq_cell.
`timescale 1ns / 1ps

// The queue holds up to QUEUE_DEPTH jobs in a row of cells kept sorted by
// priority, highest first and newest first among equal priorities. An insert
// transfer (req_tuser 0) has every cell compare its priority with the new one
// in parallel, the cells below the insert point move one place down, and a
// single result with status inserted, or full when the queue holds QUEUE_DEPTH
// jobs, is presented on the next cycle. Priorities above nine are stored as
// nine. A dump transfer (req_tuser 1) streams the stored jobs out of the head
// cell, one job per cycle while rsp_tready stays high, with rsp_tlast on the
// final job, and leaves the queue empty; a dump of an empty queue gives one
// result with status empty. A dump occupies the block until its last job is in
// the result register, the chain shifting one place toward the head per job. A
// new request is taken whenever no dump is in progress and the result register
// is empty or being read in the same cycle. Stored contents need no clearing
// after reset; only the state, occupancy count and result valid flag are reset.
module sorted_priority_job_queue #(
   parameter int QUEUE_DEPTH = spjq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // Fields from bit 0 up: priority_req[3:0], payload_low[67:4],
   // payload_high[107:68], zero fill [111:108].
   input  logic [spjq_pkg::TDATA_W-1:0] req_tdata,
   // Fields: opcode[0].
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // Fields from bit 0 up: priority_out[3:0], payload_low_out[67:4],
   // payload_high_out[107:68], zero fill [111:108].
   output logic [spjq_pkg::TDATA_W-1:0] rsp_tdata,
   // Fields: status[1:0].
   output logic [spjq_pkg::STATUS_W-1:0] rsp_tuser,
   output logic                         rsp_tlast
);
   import spjq_pkg::*;

   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;
   job_type              rsp_job_ff, rsp_job_in;

   logic                 out_free;
   logic                 accept;
   logic                 full;
   job_type              req_job;
   cell_ctrl_type        ctrl;

   job_type              cell_job [QUEUE_DEPTH];
   logic                 cell_ge  [QUEUE_DEPTH];

   // The result register can be loaded when it is empty or being read now.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == COUNT_W'(QUEUE_DEPTH));

   always_comb begin
      req_job.prio     = req_tdata[PRIO_W-1:0];
      req_job.pay_low  = req_tdata[PRIO_W +: PAY_LOW_W];
      req_job.pay_high = req_tdata[PRIO_W+PAY_LOW_W +: PAY_HIGH_W];
      // Out-of-range priorities saturate to the top priority.
      if (req_job.prio > TOP_PRIORITY) begin
         req_job.prio = TOP_PRIORITY;
      end
   end

   assign ctrl.insert     = accept && (req_tuser == OP_INSERT) && !full;
   assign ctrl.dump_shift = (state_ff == S_DUMP) && out_free;
   assign ctrl.new_job    = req_job;

   // Cell 0 is the head of the queue. Inserts shift data toward the tail,
   // dumps shift data toward the head.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic    ge_left;
      job_type job_left;
      job_type job_right;

      if (i == 0) begin : g_head
         assign ge_left  = 1'b0;
         assign job_left = '0;
      end else begin : g_body
         assign ge_left  = cell_ge[i-1];
         assign job_left = cell_job[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign job_right = '0;
      end else begin : g_inner
         assign job_right = cell_job[i+1];
      end

      spjq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (count_ff > COUNT_W'(i)),
         .ge_left   (ge_left),
         .job_left  (job_left),
         .job_right (job_right),
         .job       (cell_job[i]),
         .ge        (cell_ge[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_job_in    = rsp_job_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_job_in  = '0;
               rsp_last_in = 1'b1;
               if (req_tuser == OP_INSERT) begin
                  rsp_valid_in = 1'b1;
                  if (full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     rsp_status_in = ST_INSERTED;
                     count_in      = count_ff + COUNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_EMPTY;
               end else begin
                  state_in = S_DUMP;
               end
            end
         end
         S_DUMP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DUMPED;
               rsp_job_in    = cell_job[0];
               rsp_last_in   = (count_ff == COUNT_W'(1));
               count_in      = count_ff - COUNT_W'(1);
               if (count_ff == COUNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_job_ff    <= rsp_job_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(TDATA_W - JOB_W){1'b0}}, rsp_job_ff};

endmodule

/* src/spjq_cell.sv */
// One slot of the sorted chain: holds one job and trades it with its neighbors.
// Depends on spjq_pkg.
`timescale 1ns / 1ps

module spjq_cell (
   input  logic                   clock,
   input  spjq_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  logic                   ge_left,
   input  spjq_pkg::job_type      job_left,
   input  spjq_pkg::job_type      job_right,
   output spjq_pkg::job_type      job,
   output logic                   ge
);
   import spjq_pkg::*;

   job_type job_ff;
   job_type job_in;

   // The new job belongs at or before this slot once the slot is free or no
   // longer outranks it. Along a sorted chain this flag only turns on once.
   assign ge  = !(occupied && (job_ff.prio > ctrl.new_job.prio));
   assign job = job_ff;

   always_comb begin
      job_in = job_ff;
      if (ctrl.insert) begin
         if (ge_left) begin
            job_in = job_left;
         end else if (ge) begin
            job_in = ctrl.new_job;
         end
      end else if (ctrl.dump_shift) begin
         job_in = job_right;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

/* tb/sv/sorted_priority_job_queue_test.sv */
// Self-checking testbench for the sorted priority job queue: a directed table,
// then random traffic with bursty requests and a stalling receiver.
// Depends on spjq_pkg and sorted_priority_job_queue.
`timescale 1ns / 1ps

module sorted_priority_job_queue_test;

   import spjq_pkg::*;

   localparam int DEPTH        = QUEUE_DEPTH_DEFAULT;
   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 272;
   // A dump of a full queue keeps the block busy while DEPTH jobs stream out.
   localparam int DRAIN_CYCLES = DEPTH + 8;

   // One result as the block should present it.
   typedef struct {
      logic [STATUS_W-1:0]   status;
      logic [PRIO_W-1:0]     prio;
      logic [PAY_LOW_W-1:0]  pay_low;
      logic [PAY_HIGH_W-1:0] pay_high;
      logic                  is_final;
   } answer_type;

   // One row of the directed table. Rows with reps above one are repeated,
   // with the priority stepping up by one per copy (wrapping at 16) and the
   // payload XORed with the copy index, so every copy is distinct. Where
   // typed is set, the single result of the row is written out by hand.
   typedef struct {
      logic                  op;
      logic [PRIO_W-1:0]     prio;
      logic [PAY_LOW_W-1:0]  pay_low;
      logic [PAY_HIGH_W-1:0] pay_high;
      int                    reps;
      bit                    typed;
      logic [STATUS_W-1:0]   typed_status;
   } stim_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TDATA_W-1:0]    req_tdata  = '0;
   logic                  req_tuser  = OP_INSERT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [TDATA_W-1:0]    rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;

   // The predicted queue contents, slot 0 first, and the results still owed.
   job_type    shadow_jobs[$];
   answer_type due_results[$];

   int error_count   = 0;
   int inserts_seen  = 0;
   int rejects_seen  = 0;
   int jobs_streamed = 0;
   int empties_seen  = 0;
   int burst_left    = 0;
   int stall_mode    = 0;
   int stall_tick    = 0;

   sorted_priority_job_queue #(
      .QUEUE_DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #HALF_PERIOD clock = ~clock;

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      error_count++;
      $display("MISMATCH at %0t: %s got %0h, want %0h", $realtime, what, got, want);
   endtask

   // Applies one accepted request to the shadow queue and appends the results
   // it causes. Inserts land ahead of every job of lower or equal priority,
   // so among equal priorities the newest job is served first.
   function automatic void shadow_apply(input logic op, input logic [PRIO_W-1:0] prio,
                                        input logic [PAY_LOW_W-1:0] pay_low,
                                        input logic [PAY_HIGH_W-1:0] pay_high);
      job_type    job;
      answer_type ans;
      int         pos;
      ans = '{ST_INSERTED, '0, '0, '0, 1'b1};
      if (op == OP_INSERT) begin
         if (shadow_jobs.size() >= DEPTH) begin
            ans.status = ST_FULL;
         end else begin
            job.prio     = (prio > TOP_PRIORITY) ? TOP_PRIORITY : prio;
            job.pay_low  = pay_low;
            job.pay_high = pay_high;
            pos = 0;
            while (pos < shadow_jobs.size() && shadow_jobs[pos].prio > job.prio) pos++;
            shadow_jobs.insert(pos, job);
         end
         due_results.push_back(ans);
      end else if (shadow_jobs.size() == 0) begin
         ans.status = ST_EMPTY;
         due_results.push_back(ans);
      end else begin
         foreach (shadow_jobs[i]) begin
            ans = '{ST_DUMPED, shadow_jobs[i].prio, shadow_jobs[i].pay_low,
                    shadow_jobs[i].pay_high, (i == shadow_jobs.size() - 1)};
            due_results.push_back(ans);
         end
         shadow_jobs.delete();
      end
   endfunction

   // Presents one request at the falling edge and holds it until a rising
   // edge sees tready. After the transfer the sender either carries on with
   // its current burst or drops tvalid for a random gap.
   task automatic send_request(input logic op, input logic [PRIO_W-1:0] prio,
                               input logic [PAY_LOW_W-1:0] pay_low,
                               input logic [PAY_HIGH_W-1:0] pay_high,
                               input bit typed, input logic [STATUS_W-1:0] typed_status);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(TDATA_W - JOB_W){1'b0}}, pay_high, pay_low, prio};
      do @(posedge clock); while (!req_tready);
      shadow_apply(op, prio, pay_low, pay_high);
      // A typed row causes exactly one result; the hand-written one stands in
      // for what the shadow queue produced.
      if (typed)
         due_results[due_results.size() - 1] = '{typed_status, '0, '0, '0, 1'b1};
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
         burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(0, 10);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Lowers tvalid and waits until every owed result has been taken.
   task automatic quiesce();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   // The receiver picks one of four stall patterns at regular intervals: always
   // ready, coin flips, a short duty cycle, and long stalls.
   always @(negedge clock) begin
      stall_tick = stall_tick + 1;
      if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (stall_tick % 8) < 5;
         default: rsp_tready <= (stall_tick % 32) >= 12;
      endcase
   end

   // Every result transfer is checked field by field against the oldest
   // owed result.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            flag_mismatch("result with nothing owed, status", rsp_tuser, '0);
         end else begin
            want = due_results.pop_front();
            if (rsp_tuser !== want.status)
               flag_mismatch("status", rsp_tuser, want.status);
            if (rsp_tdata[PRIO_W-1:0] !== want.prio)
               flag_mismatch("priority", rsp_tdata[PRIO_W-1:0], want.prio);
            if (rsp_tdata[PRIO_W +: PAY_LOW_W] !== want.pay_low)
               flag_mismatch("payload low", rsp_tdata[PRIO_W +: PAY_LOW_W], want.pay_low);
            if (rsp_tdata[PRIO_W + PAY_LOW_W +: PAY_HIGH_W] !== want.pay_high)
               flag_mismatch("payload high", rsp_tdata[PRIO_W + PAY_LOW_W +: PAY_HIGH_W],
                             want.pay_high);
            if (rsp_tlast !== want.is_final)
               flag_mismatch("tlast", rsp_tlast, want.is_final);
         end
         case (rsp_tuser)
            ST_INSERTED: inserts_seen++;
            ST_FULL:     rejects_seen++;
            ST_DUMPED:   jobs_streamed++;
            default:     empties_seen++;
         endcase
      end
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #10_000_000;
      $display("Timeout with %0d results still owed.", due_results.size());
      $display("sorted_priority_job_queue_test: done, errors");
      $finish;
   end

   initial begin
      stim_row_type          rows [0:16];
      int                    dump_odds;
      bit                    narrow;
      logic [PRIO_W-1:0]     prio_a;
      logic [PRIO_W-1:0]     prio_b;
      logic [PRIO_W-1:0]     prio;
      logic                  op;

      rows = '{
         // A dump straight after reset finds the queue empty.
         '{OP_DUMP,   4'd0,  64'h0, 40'h0, 1, 1'b1, ST_EMPTY},
         // Payload extremes, and priorities above nine that saturate.
         '{OP_INSERT, 4'd0,  64'h0, 40'h0, 1, 1'b1, ST_INSERTED},
         '{OP_INSERT, 4'd9,  64'hFFFF_FFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1, 1'b1, ST_INSERTED},
         '{OP_INSERT, 4'd15, 64'h5555_5555_5555_5555, 40'hAA_AAAA_AAAA, 1, 1'b1, ST_INSERTED},
         '{OP_INSERT, 4'd10, 64'hAAAA_AAAA_AAAA_AAAA, 40'h55_5555_5555, 1, 1'b1, ST_INSERTED},
         '{OP_INSERT, 4'd0,  64'h0123_4567_89AB_CDEF, 40'h01_2345_6789, 1, 1'b1, ST_INSERTED},
         '{OP_INSERT, 4'd4,  64'hDEAD_BEEF_0000_0001, 40'h80_0000_0001, 1, 1'b0, ST_INSERTED},
         // The dump order checks the sort and the newest-first tie rule.
         '{OP_DUMP,   4'd0,  64'h0, 40'h0, 1, 1'b0, ST_INSERTED},
         '{OP_DUMP,   4'd0,  64'h0, 40'h0, 1, 1'b1, ST_EMPTY},
         // A single stored job dumps as one result carrying tlast.
         '{OP_INSERT, 4'd3,  64'h8000_0000_0000_0000, 40'h7F_FFFF_FFFF, 1, 1'b1, ST_INSERTED},
         '{OP_DUMP,   4'd0,  64'h0, 40'h0, 1, 1'b0, ST_INSERTED},
         // Fill the queue with mixed priorities, then push on a full queue.
         '{OP_INSERT, 4'd5,  64'hC3C3_0F0F_3C3C_F0F0, 40'h12_3456_789A, DEPTH, 1'b0, ST_INSERTED},
         '{OP_INSERT, 4'd7,  64'h1, 40'h1, 1, 1'b1, ST_FULL},
         '{OP_INSERT, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1, 1'b1, ST_FULL},
         '{OP_DUMP,   4'd0,  64'h0, 40'h0, 1, 1'b0, ST_INSERTED},
         // The queue is usable again after a full dump.
         '{OP_INSERT, 4'd9,  64'h7777_8888_9999_AAAA, 40'hBB_CCCC_DDDD, 1, 1'b1, ST_INSERTED},
         '{OP_DUMP,   4'd0,  64'h0, 40'h0, 1, 1'b0, ST_INSERTED}
      };

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      foreach (rows[r]) begin
         for (int k = 0; k < rows[r].reps; k++) begin
            send_request(rows[r].op, rows[r].prio + PRIO_W'(k), rows[r].pay_low ^ k,
                         rows[r].pay_high ^ k, rows[r].typed, rows[r].typed_status);
         end
      end

      // Random traffic in phases of 40 transfers. Each phase picks how often
      // it dumps: often, now and then, or rarely enough that the queue fills
      // and inserts get rejected. Half the phases draw priorities from just
      // two values so that ties pile up.
      dump_odds = 3;
      narrow    = 1'b0;
      prio_a    = '0;
      prio_b    = '0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: dump_odds = 3;
               1: dump_odds = 12;
               default: dump_odds = 70;
            endcase
            narrow = 1'($urandom_range(0, 1));
            prio_a = PRIO_W'($urandom_range(0, 15));
            prio_b = PRIO_W'($urandom_range(0, 15));
         end
         // Once mid-run the sender holds off until the block has drained.
         if (n == RANDOM_ITEMS / 2) quiesce();
         op   = ($urandom_range(1, dump_odds) == 1) ? OP_DUMP : OP_INSERT;
         prio = narrow ? ($urandom_range(0, 1) ? prio_a : prio_b)
                       : PRIO_W'($urandom_range(0, 15));
         send_request(op, prio, {$urandom, $urandom}, PAY_HIGH_W'({$urandom, $urandom}),
                      1'b0, ST_INSERTED);
      end
      // A final dump so the run ends on an empty queue.
      send_request(OP_DUMP, '0, '0, '0, 1'b0, ST_INSERTED);

      quiesce();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d inserts, %0d rejections on a full queue,", inserts_seen,
               rejects_seen);
      $display("%0d jobs streamed out by dumps and %0d dumps of an empty queue.",
               jobs_streamed, empties_seen);
      if (error_count == 0 && due_results.size() == 0) begin
         $display("sorted_priority_job_queue_test: done, clean");
      end else begin
         $display("sorted_priority_job_queue_test: done, errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/spjq_pkg.sv
src/spjq_cell.sv
src/sorted_priority_job_queue.sv
tb/sv/sorted_priority_job_queue_test.sv
